// ===== hdl/wtc_pkg.sv =====
// wtc_pkg: shared types, token class codes, character codes and the exact-word table
// for the word token classifier; no dependencies
package wtc_pkg;

  localparam int LENGTH_LIMIT = 255;
  localparam int PREFIX_DEPTH = 6;
  localparam int PREFIX_W     = PREFIX_DEPTH * 8;
  localparam int CNT_W        = $clog2(LENGTH_LIMIT + 1);
  localparam int CLS_W        = 5;
  localparam int LEN_W        = 8;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FCNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_EXACT    = 28;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [CLS_W-1:0] TOK_IDENT  = 5'd0;
  localparam logic [CLS_W-1:0] TOK_ADD    = 5'd1;
  localparam logic [CLS_W-1:0] TOK_MUL    = 5'd2;
  localparam logic [CLS_W-1:0] TOK_END    = 5'd3;
  localparam logic [CLS_W-1:0] TOK_INT    = 5'd4;
  localparam logic [CLS_W-1:0] TOK_REAL   = 5'd5;
  localparam logic [CLS_W-1:0] TOK_REL    = 5'd6;
  localparam logic [CLS_W-1:0] TOK_OR     = 5'd7;
  localparam logic [CLS_W-1:0] TOK_AND    = 5'd8;
  localparam logic [CLS_W-1:0] TOK_NOT    = 5'd9;
  localparam logic [CLS_W-1:0] TOK_EQ     = 5'd10;
  localparam logic [CLS_W-1:0] TOK_SEMI   = 5'd11;
  localparam logic [CLS_W-1:0] TOK_COMMA  = 5'd12;
  localparam logic [CLS_W-1:0] TOK_LPAR   = 5'd13;
  localparam logic [CLS_W-1:0] TOK_RPAR   = 5'd14;
  localparam logic [CLS_W-1:0] TOK_LBRACE = 5'd15;
  localparam logic [CLS_W-1:0] TOK_RBRACE = 5'd16;
  localparam logic [CLS_W-1:0] TOK_ASSIGN = 5'd17;
  localparam logic [CLS_W-1:0] TOK_IF     = 5'd18;
  localparam logic [CLS_W-1:0] TOK_WHILE  = 5'd19;
  localparam logic [CLS_W-1:0] TOK_RETURN = 5'd20;
  localparam logic [CLS_W-1:0] TOK_ELSE   = 5'd21;
  localparam logic [CLS_W-1:0] TOK_STRING = 5'd22;
  localparam logic [CLS_W-1:0] TOK_TYPE   = 5'd23;

  // first character in the top byte, unused bytes zero
  localparam logic [PREFIX_W-1:0] EXACT_TEXT [NUM_EXACT] = '{
    {"+", 40'h0}, {"-", 40'h0},
    {"*", 40'h0}, {"/", 40'h0},
    {"<", 40'h0}, {"<=", 32'h0}, {">", 40'h0}, {">=", 32'h0},
    {"||", 32'h0},
    {"&&", 32'h0},
    {"!", 40'h0},
    {"!=", 32'h0}, {"==", 32'h0},
    {";", 40'h0}, {",", 40'h0}, {"(", 40'h0}, {")", 40'h0},
    {"{", 40'h0}, {"}", 40'h0}, {"=", 40'h0},
    {"if", 32'h0}, {"while", 8'h0}, "return", {"else", 16'h0},
    {"int", 24'h0}, {"float", 8'h0}, {"void", 16'h0}, {"char", 16'h0}
  };

  localparam logic [2:0] EXACT_LEN [NUM_EXACT] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd5, 3'd6, 3'd4, 3'd3, 3'd5, 3'd4, 3'd4
  };

  localparam logic [CLS_W-1:0] EXACT_CLS [NUM_EXACT] = '{
    TOK_ADD, TOK_ADD, TOK_MUL, TOK_MUL,
    TOK_REL, TOK_REL, TOK_REL, TOK_REL,
    TOK_OR, TOK_AND, TOK_NOT, TOK_EQ, TOK_EQ,
    TOK_SEMI, TOK_COMMA, TOK_LPAR, TOK_RPAR, TOK_LBRACE, TOK_RBRACE, TOK_ASSIGN,
    TOK_IF, TOK_WHILE, TOK_RETURN, TOK_ELSE,
    TOK_TYPE, TOK_TYPE, TOK_TYPE, TOK_TYPE
  };

  typedef struct packed {
    logic [PREFIX_DEPTH-1:0][7:0] prefix;
    logic [CNT_W-1:0]             count;
    logic                         all_digits;
    logic                         digits_or_dots;
    logic                         saw_quote;
  } word_state_t;

  typedef struct packed {
    logic       clear;
    logic       add;
    logic [7:0] ch;
  } word_ctl_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] c);
    return (32'(c) > 32'd255) ? 8'hFF : LEN_W'(c);
  endfunction

endpackage

// ===== hdl/wtc_word_acc.sv =====
// wtc_word_acc: state of the word being scanned (prefix, count, class flags)
// depends on wtc_pkg
module wtc_word_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  wtc_pkg::word_ctl_t  ctl,
  output wtc_pkg::word_state_t ws
);

  wtc_pkg::word_state_t ws_r, ws_nxt;
  logic digit;

  assign digit = (ctl.ch >= wtc_pkg::CH_ZERO) && (ctl.ch <= wtc_pkg::CH_NINE);

  always_comb begin
    ws_nxt = ws_r;
    if (ctl.clear) begin
      ws_nxt.prefix         = '0;
      ws_nxt.count          = '0;
      ws_nxt.all_digits     = 1'b1;
      ws_nxt.digits_or_dots = 1'b1;
      ws_nxt.saw_quote      = 1'b0;
    end else if (ctl.add) begin
      for (int i = 0; i < wtc_pkg::PREFIX_DEPTH; i++) begin
        if (32'(ws_r.count) == i) begin
          ws_nxt.prefix[wtc_pkg::PREFIX_DEPTH-1-i] = ctl.ch;
        end
      end
      if (32'(ws_r.count) < wtc_pkg::LENGTH_LIMIT) begin
        ws_nxt.count = ws_r.count + 1'b1;
      end
      if (!digit) begin
        ws_nxt.all_digits = 1'b0;
      end
      if (!digit && ctl.ch != wtc_pkg::CH_DOT) begin
        ws_nxt.digits_or_dots = 1'b0;
      end
      if (ctl.ch == wtc_pkg::CH_QUOTE) begin
        ws_nxt.saw_quote = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r.prefix         <= '0;
      ws_r.count          <= '0;
      ws_r.all_digits     <= 1'b1;
      ws_r.digits_or_dots <= 1'b1;
      ws_r.saw_quote      <= 1'b0;
    end else begin
      ws_r <= ws_nxt;
    end
  end

  assign ws = ws_r;

endmodule

// ===== hdl/wtc_classify.sv =====
// wtc_classify: token class of the pending word from its prefix, length and flags
// depends on wtc_pkg
module wtc_classify (
  input  wtc_pkg::word_state_t        ws,
  output logic [wtc_pkg::CLS_W-1:0]   cls
);

  logic                       found;
  logic [wtc_pkg::CLS_W-1:0]  exact_cls;

  always_comb begin
    found     = 1'b0;
    exact_cls = wtc_pkg::TOK_IDENT;
    for (int k = 0; k < wtc_pkg::NUM_EXACT; k++) begin
      if (!found && (32'(ws.count) == 32'(wtc_pkg::EXACT_LEN[k])) &&
          (ws.prefix == wtc_pkg::EXACT_TEXT[k])) begin
        found     = 1'b1;
        exact_cls = wtc_pkg::EXACT_CLS[k];
      end
    end
  end

  always_comb begin
    if (found) begin
      cls = exact_cls;
    end else if (ws.all_digits) begin
      cls = wtc_pkg::TOK_INT;
    end else if (ws.digits_or_dots) begin
      cls = wtc_pkg::TOK_REAL;
    end else if (ws.saw_quote) begin
      cls = wtc_pkg::TOK_STRING;
    end else begin
      cls = wtc_pkg::TOK_IDENT;
    end
  end

endmodule

// ===== hdl/wtc_result_fifo.sv =====
// wtc_result_fifo: small result queue taking up to two results per cycle, one out
// depends on wtc_pkg
module wtc_result_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_n,
  input  wtc_pkg::result_t             push0,
  input  wtc_pkg::result_t             push1,
  output logic                         room2,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wtc_pkg::result_t             out_res
);

  wtc_pkg::result_t               mem_r [wtc_pkg::FIFO_DEPTH];
  logic [wtc_pkg::PTR_W-1:0]      wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [wtc_pkg::FCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (32'(cnt_r) + 2 <= wtc_pkg::FIFO_DEPTH);
  assign wr_p1     = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + wtc_pkg::PTR_W'(push_n);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + wtc_pkg::FCNT_W'(push_n) - wtc_pkg::FCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) + 32'(push_n) <= wtc_pkg::FIFO_DEPTH + 32'(pop))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> 32'(cnt_r) == 32'($past(cnt_r)) + 32'($past(push_n)) - 32'($past(pop)))
    else $error("result queue count out of step");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    wtc_pkg::PTR_W'(wr_r - rd_r) == wtc_pkg::PTR_W'(cnt_r))
    else $error("result queue pointers disagree with count");

endmodule

// ===== hdl/word_token_classifier_core.sv =====
// word_token_classifier_core: top level, splits a byte stream into words and classifies them
// depends on wtc_pkg, wtc_word_acc, wtc_classify, wtc_result_fifo
//
// One text byte is taken per cycle whenever the queue has room for two results, so with
// the output side ready the block sustains one byte per clock. A word is classified in the
// cycle its closing space or end-of-text flag is taken, from the word state registers
// into a four-entry result queue; a leading '$' with no word pending queues an end
// result. Results leave one per cycle while the output side is ready; an end-of-text
// transfer with a pending word queues two results. No clearing pass is needed after reset.
module word_token_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] word_length
  output logic [4:0]  out_tuser,  // [4:0] token_class
  output logic        out_tlast   // last_of_run
);

  wtc_pkg::word_state_t          ws;
  wtc_pkg::word_ctl_t            ctl;
  wtc_pkg::result_t              push0, push1, out_res;
  logic [wtc_pkg::CLS_W-1:0]     cls;
  logic [1:0]                    push_n;
  logic                          accept, has_word, room2;

  assign accept   = in_tvalid && in_tready;
  assign has_word = (ws.count != '0);

  wtc_word_acc u_word (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ws    (ws)
  );

  wtc_classify u_cls (
    .ws  (ws),
    .cls (cls)
  );

  always_comb begin
    ctl.clear = 1'b0;
    ctl.add   = 1'b0;
    ctl.ch    = in_tdata;
    push_n    = 2'd0;
    push0     = '{cls: cls, len: wtc_pkg::sat_len(ws.count), last: 1'b1};
    push1     = '{cls: wtc_pkg::TOK_END, len: '0, last: 1'b1};
    if (accept) begin
      if (in_tlast) begin
        ctl.clear = 1'b1;
        if (has_word) begin
          push0.last = 1'b0;
          push_n     = 2'd2;
        end else begin
          push0  = '{cls: wtc_pkg::TOK_END, len: '0, last: 1'b1};
          push_n = 2'd1;
        end
      end else if (in_tdata == wtc_pkg::CH_SPACE) begin
        if (has_word) begin
          ctl.clear = 1'b1;
          push_n    = 2'd1;
        end
      end else if (in_tdata == wtc_pkg::CH_DOLLAR && !has_word) begin
        ctl.clear = 1'b1;
        push0     = '{cls: wtc_pkg::TOK_END, len: 8'd1, last: 1'b1};
        push_n    = 2'd1;
      end else begin
        ctl.add = 1'b1;
      end
    end
  end

  wtc_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (push1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign in_tready = room2;
  assign out_tdata = out_res.len;
  assign out_tuser = out_res.cls;
  assign out_tlast = out_res.last;

  a_clear_on_eot: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> ws.count == '0)
    else $error("word state not cleared after end of text");

  a_space_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tlast && in_tdata == wtc_pkg::CH_SPACE |=> ws.count == '0)
    else $error("space left a pending word");

  a_two_only_eot: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> accept && in_tlast && has_word)
    else $error("two results from a transfer that is not end of text");

endmodule
